// ===== rtl/mlfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared codes, states and reset constants of the feedback-queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_ARRIVE = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	localparam logic [1:0] LVL_HIGH = 2'd0;
	localparam logic [1:0] LVL_MED  = 2'd1;
	localparam logic [1:0] LVL_LOW  = 2'd2;

	localparam logic [7:0] BOOST_RESET = 8'd10;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD,
		ST_AR,
		ST_AR_B,
		ST_BM,
		ST_BL,
		ST_SEL,
		ST_CPU,
		ST_CPU_B,
		ST_IOSEL,
		ST_IO,
		ST_IO_B,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/mlfq_scheduler_with_io_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_scheduler_with_io_queue
// Three-level feedback-queue scheduler with a FIFO I/O server. Queues are
// linked lists through a next-pointer RAM; burst lengths and per-process
// records live in RAMs and are updated by read-modify-write.
// ----------------------------------------------------------------------------
// channel   ports                                         handshake
// command   cmd proc_id burst_len last_burst              start & !busy
// result    cpu_valid cpu_proc cpu_level proc_finished    done (one cycle)
//           io_valid io_proc all_idle
// config    cfg_wdata                                     cfg_we
//
// Load and arrive read the process record, then may write it back; cmd 3 or an
// out-of-range process is ignored. A tick runs two boost-link steps, then one RAM
// read and one write-back each for the CPU and the I/O process.
// A tick's result is shown with done in the cycle before busy drops.
// Reset clears all queues and records at once; no sweep.
// ----------------------------------------------------------------------------
module mlfq_scheduler_with_io_queue #(
	parameter int MAX_PROCS  = 16,
	parameter int MAX_BURSTS = 16,
	parameter int BURST_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [3:0]  proc_id,
	input  logic [15:0] burst_len,
	input  logic        last_burst,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output logic        done,
	output logic        cpu_valid,
	output logic [3:0]  cpu_proc,
	output logic [1:0]  cpu_level,
	output logic        proc_finished,
	output logic        io_valid,
	output logic [3:0]  io_proc,
	output logic        all_idle
);

	localparam int PW = $clog2(MAX_PROCS);
	localparam int CW = $clog2(MAX_BURSTS + 1);
	localparam int SW = $clog2(MAX_PROCS + 1);
	localparam int AW = $clog2(MAX_PROCS * MAX_BURSTS);
	localparam int RW = BURST_BITS;

	typedef struct packed {
		logic          active;
		logic          sealed;
		logic [CW-1:0] count;
		logic [CW-1:0] index;
		logic [RW-1:0] remain;
	} prec_t;

	localparam int RECW = $bits(prec_t);

	function automatic logic [AW-1:0] baddr(input logic [PW-1:0] p, input logic [CW-1:0] i);
		return AW'(AW'(p) * AW'(MAX_BURSTS)) + AW'(i);
	endfunction

	function automatic logic [RW-1:0] fixlen(input logic [RW-1:0] v);
		return (v == '0) ? RW'(1) : v;
	endfunction

	mlfq_pkg::state_t state_q, state_d;

	logic [PW-1:0] p_q, p_d;
	logic [RW-1:0] len_q, len_d;
	logic          last_q, last_d;
	logic          boost_q, boost_d;
	logic          hold_q, hold_d;
	logic [1:0]    lvl_q, lvl_d;
	logic [PW-1:0] cur_q, cur_d;
	prec_t         rec_q, rec_d;
	logic [7:0]    bc_q, bc_d;
	logic [7:0]    bp_q;

	logic [PW-1:0] hh_q, hh_d, ht_q, ht_d, mh_q, mh_d, mt_q, mt_d;
	logic [PW-1:0] lh_q, lh_d, lt_q, lt_d, ih_q, ih_d, it_q, it_d;
	logic [SW-1:0] hs_q, hs_d, ms_q, ms_d, ls_q, ls_d, is_q, is_d;

	logic       ocv_q, ocv_d, ofin_q, ofin_d, oiv_q, oiv_d, oidle_q, oidle_d;
	logic [3:0] ocp_q, ocp_d, oip_q, oip_d;
	logic [1:0] olvl_q, olvl_d;

	logic          pt_we;
	logic [PW-1:0] pt_waddr, pt_raddr;
	prec_t         pt_wd, pt_rd;
	logic          bs_we;
	logic [AW-1:0] bs_waddr, bs_raddr;
	logic [RW-1:0] bs_wd, bs_rd;
	logic          nx_we;
	logic [PW-1:0] nx_waddr, nx_wd, nx_raddr, nx_rd;

	logic          in_range;
	logic [7:0]    period;
	logic [8:0]    bc_inc;
	prec_t         r;

	mlfq_ptab #(.DEPTH(MAX_PROCS), .AW(PW), .W(RECW)) u_ptab (
		.clk(clk), .arst_n(arst_n), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wd),
		.raddr(pt_raddr), .rdata(pt_rd)
	);

	mlfq_ram #(.DEPTH(MAX_PROCS * MAX_BURSTS), .AW(AW), .W(RW)) u_bst (
		.clk(clk), .we(bs_we), .waddr(bs_waddr), .wdata(bs_wd),
		.raddr(bs_raddr), .rdata(bs_rd)
	);

	mlfq_ram #(.DEPTH(MAX_PROCS), .AW(PW), .W(PW)) u_nxt (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wd),
		.raddr(nx_raddr), .rdata(nx_rd)
	);

	assign in_range = (32'(proc_id) < MAX_PROCS);
	assign period = (bp_q == 8'd0) ? 8'd1 : bp_q;
	assign bc_inc = {1'b0, bc_q} + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlfq_pkg::ST_IDLE;
			bc_q <= '0;
			bp_q <= mlfq_pkg::BOOST_RESET;
			boost_q <= 1'b0;
			hold_q <= 1'b0;
			hs_q <= '0;
			ms_q <= '0;
			ls_q <= '0;
			is_q <= '0;
		end else begin
			state_q <= state_d;
			bc_q <= bc_d;
			if (cfg_we) begin
				bp_q <= cfg_wdata;
			end
			boost_q <= boost_d;
			hold_q <= hold_d;
			hs_q <= hs_d;
			ms_q <= ms_d;
			ls_q <= ls_d;
			is_q <= is_d;
		end
	end

	always_ff @(posedge clk) begin
		p_q <= p_d;
		len_q <= len_d;
		last_q <= last_d;
		lvl_q <= lvl_d;
		cur_q <= cur_d;
		rec_q <= rec_d;
		hh_q <= hh_d;
		ht_q <= ht_d;
		mh_q <= mh_d;
		mt_q <= mt_d;
		lh_q <= lh_d;
		lt_q <= lt_d;
		ih_q <= ih_d;
		it_q <= it_d;
		ocv_q <= ocv_d;
		ocp_q <= ocp_d;
		olvl_q <= olvl_d;
		ofin_q <= ofin_d;
		oiv_q <= oiv_d;
		oip_q <= oip_d;
		oidle_q <= oidle_d;
	end

	always_comb begin
		state_d = state_q;
		p_d = p_q;
		len_d = len_q;
		last_d = last_q;
		boost_d = boost_q;
		hold_d = hold_q;
		lvl_d = lvl_q;
		cur_d = cur_q;
		rec_d = rec_q;
		bc_d = bc_q;
		hh_d = hh_q; ht_d = ht_q; hs_d = hs_q;
		mh_d = mh_q; mt_d = mt_q; ms_d = ms_q;
		lh_d = lh_q; lt_d = lt_q; ls_d = ls_q;
		ih_d = ih_q; it_d = it_q; is_d = is_q;
		ocv_d = ocv_q; ocp_d = ocp_q; olvl_d = olvl_q; ofin_d = ofin_q;
		oiv_d = oiv_q; oip_d = oip_q; oidle_d = oidle_q;
		pt_we = 1'b0; pt_waddr = cur_q; pt_wd = rec_q; pt_raddr = cur_q;
		bs_we = 1'b0; bs_waddr = '0; bs_wd = len_q; bs_raddr = '0;
		nx_we = 1'b0; nx_waddr = '0; nx_wd = cur_q; nx_raddr = cur_q;
		r = pt_rd;

		unique case (state_q)
			mlfq_pkg::ST_IDLE: begin
				if (start) begin
					p_d = PW'(proc_id);
					len_d = RW'(burst_len);
					last_d = last_burst;
					if (cmd == mlfq_pkg::CMD_TICK) begin
						state_d = mlfq_pkg::ST_BM;
					end else if (in_range && cmd == mlfq_pkg::CMD_LOAD) begin
						pt_raddr = PW'(proc_id);
						state_d = mlfq_pkg::ST_LD;
					end else if (in_range && cmd == mlfq_pkg::CMD_ARRIVE) begin
						pt_raddr = PW'(proc_id);
						state_d = mlfq_pkg::ST_AR;
					end
				end
			end
			mlfq_pkg::ST_LD: begin
				r = pt_rd;
				if (!r.active) begin
					if (r.sealed) begin
						r.count = '0;
						r.sealed = 1'b0;
					end
					if (r.count < CW'(MAX_BURSTS)) begin
						bs_we = 1'b1;
						bs_waddr = baddr(p_q, r.count);
						bs_wd = len_q;
						r.count = r.count + CW'(1);
						if (last_q) begin
							r.sealed = 1'b1;
						end
					end
					pt_we = 1'b1;
					pt_waddr = p_q;
					pt_wd = r;
				end
				state_d = mlfq_pkg::ST_IDLE;
			end
			mlfq_pkg::ST_AR: begin
				r = pt_rd;
				if (!r.active && r.count != '0) begin
					bs_raddr = baddr(p_q, '0);
					rec_d = r;
					state_d = mlfq_pkg::ST_AR_B;
				end else begin
					state_d = mlfq_pkg::ST_IDLE;
				end
			end
			mlfq_pkg::ST_AR_B: begin
				r = rec_q;
				r.index = '0;
				r.remain = fixlen(bs_rd);
				r.active = 1'b1;
				pt_we = 1'b1;
				pt_waddr = p_q;
				pt_wd = r;
				if (hs_q == '0) begin
					hh_d = p_q;
				end else begin
					nx_we = 1'b1;
					nx_waddr = ht_q;
					nx_wd = p_q;
				end
				ht_d = p_q;
				hs_d = hs_q + SW'(1);
				state_d = mlfq_pkg::ST_IDLE;
			end
			mlfq_pkg::ST_BM: begin
				boost_d = (bc_q == 8'd0);
				bc_d = (bc_inc >= {1'b0, period}) ? 8'd0 : bc_inc[7:0];
				if (bc_q == 8'd0 && ms_q != '0) begin
					if (hs_q == '0) begin
						hh_d = mh_q;
					end else begin
						nx_we = 1'b1;
						nx_waddr = ht_q;
						nx_wd = mh_q;
					end
					ht_d = mt_q;
					hs_d = hs_q + ms_q;
					ms_d = '0;
				end
				state_d = mlfq_pkg::ST_BL;
			end
			mlfq_pkg::ST_BL: begin
				if (boost_q && ls_q != '0) begin
					if (hs_q == '0) begin
						hh_d = lh_q;
					end else begin
						nx_we = 1'b1;
						nx_waddr = ht_q;
						nx_wd = lh_q;
					end
					ht_d = lt_q;
					hs_d = hs_q + ls_q;
					ls_d = '0;
				end
				state_d = mlfq_pkg::ST_SEL;
			end
			mlfq_pkg::ST_SEL: begin
				hold_d = 1'b0;
				ocv_d = 1'b0;
				ocp_d = '0;
				olvl_d = mlfq_pkg::LVL_HIGH;
				ofin_d = 1'b0;
				state_d = mlfq_pkg::ST_CPU;
				if (hs_q != '0) begin
					lvl_d = mlfq_pkg::LVL_HIGH;
					cur_d = hh_q;
				end else if (ms_q != '0) begin
					lvl_d = mlfq_pkg::LVL_MED;
					cur_d = mh_q;
				end else if (ls_q != '0) begin
					lvl_d = mlfq_pkg::LVL_LOW;
					cur_d = lh_q;
				end else begin
					state_d = mlfq_pkg::ST_IOSEL;
				end
				if (hs_q != '0 || ms_q != '0 || ls_q != '0) begin
					ocv_d = 1'b1;
					ocp_d = 4'(cur_d);
					olvl_d = lvl_d;
				end
				pt_raddr = cur_d;
				nx_raddr = cur_d;
			end
			mlfq_pkg::ST_CPU: begin
				r = pt_rd;
				case (lvl_q)
					mlfq_pkg::LVL_HIGH: begin
						hh_d = nx_rd;
						hs_d = hs_q - SW'(1);
					end
					mlfq_pkg::LVL_MED: begin
						mh_d = nx_rd;
						ms_d = ms_q - SW'(1);
					end
					default: begin
						lh_d = nx_rd;
						ls_d = ls_q - SW'(1);
					end
				endcase
				r.remain = r.remain - RW'(1);
				state_d = mlfq_pkg::ST_IOSEL;
				if (r.remain != '0) begin
					pt_we = 1'b1;
					pt_wd = r;
					if (lvl_q == mlfq_pkg::LVL_HIGH) begin
						if (ms_d == '0) begin
							mh_d = cur_q;
						end else begin
							nx_we = 1'b1;
							nx_waddr = mt_q;
						end
						mt_d = cur_q;
						ms_d = ms_d + SW'(1);
					end else begin
						if (ls_d == '0) begin
							lh_d = cur_q;
						end else begin
							nx_we = 1'b1;
							nx_waddr = lt_q;
						end
						lt_d = cur_q;
						ls_d = ls_d + SW'(1);
					end
				end else begin
					r.index = r.index + CW'(1);
					if (r.index < r.count) begin
						bs_raddr = baddr(cur_q, r.index);
						rec_d = r;
						state_d = mlfq_pkg::ST_CPU_B;
					end else begin
						ofin_d = 1'b1;
						r.active = 1'b0;
						pt_we = 1'b1;
						pt_wd = r;
					end
				end
			end
			mlfq_pkg::ST_CPU_B: begin
				r = rec_q;
				r.remain = fixlen(bs_rd);
				pt_we = 1'b1;
				pt_wd = r;
				if (is_q == '0) begin
					ih_d = cur_q;
					hold_d = 1'b1;
				end else begin
					nx_we = 1'b1;
					nx_waddr = it_q;
				end
				it_d = cur_q;
				is_d = is_q + SW'(1);
				state_d = mlfq_pkg::ST_IOSEL;
			end
			mlfq_pkg::ST_IOSEL: begin
				oidle_d = !ocv_q && (is_q == '0);
				oiv_d = 1'b0;
				oip_d = '0;
				pt_raddr = ih_q;
				nx_raddr = ih_q;
				if (!hold_q && is_q != '0) begin
					cur_d = ih_q;
					oiv_d = 1'b1;
					oip_d = 4'(ih_q);
					state_d = mlfq_pkg::ST_IO;
				end else begin
					state_d = mlfq_pkg::ST_OUT;
				end
			end
			mlfq_pkg::ST_IO: begin
				r = pt_rd;
				r.remain = r.remain - RW'(1);
				state_d = mlfq_pkg::ST_OUT;
				if (r.remain != '0) begin
					pt_we = 1'b1;
					pt_wd = r;
				end else begin
					ih_d = nx_rd;
					is_d = is_q - SW'(1);
					r.index = r.index + CW'(1);
					if (r.index < r.count) begin
						bs_raddr = baddr(cur_q, r.index);
						rec_d = r;
						state_d = mlfq_pkg::ST_IO_B;
					end else begin
						r.active = 1'b0;
						pt_we = 1'b1;
						pt_wd = r;
					end
				end
			end
			mlfq_pkg::ST_IO_B: begin
				r = rec_q;
				r.remain = fixlen(bs_rd);
				pt_we = 1'b1;
				pt_wd = r;
				if (hs_q == '0) begin
					hh_d = cur_q;
				end else begin
					nx_we = 1'b1;
					nx_waddr = ht_q;
				end
				ht_d = cur_q;
				hs_d = hs_q + SW'(1);
				state_d = mlfq_pkg::ST_OUT;
			end
			mlfq_pkg::ST_OUT: begin
				state_d = mlfq_pkg::ST_IDLE;
			end
			default: begin
				state_d = mlfq_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != mlfq_pkg::ST_IDLE);
	assign done = (state_q == mlfq_pkg::ST_OUT);
	assign cpu_valid = ocv_q;
	assign cpu_proc = ocp_q;
	assign cpu_level = olvl_q;
	assign proc_finished = ofin_q;
	assign io_valid = oiv_q;
	assign io_proc = oip_q;
	assign all_idle = oidle_q;

endmodule

// ===== rtl/mlfq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module mlfq_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int W     = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mlfq_ptab.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_ptab
// Per-process record memory; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module mlfq_ptab #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int W     = 28
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [W-1:0] rd_q;
	logic rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rv_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rv_q ? rd_q : '0;

endmodule
